// ===== rtl/affine_vertex_transform_2d_top_defines.svh =====
// assertion macros for the affine vertex transform block
// set NO_ASSERTIONS to compile the checks out
`ifndef AFFINE_VERTEX_TRANSFORM_2D_TOP_DEFINES_SVH
`define AFFINE_VERTEX_TRANSFORM_2D_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// antecedent holds, consequent must hold in the same cycle
`define AVT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent holds, consequent must hold in the next cycle
`define AVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define AVT_ASSERT_NOW(lbl, clk, rst_n, ante, cons)

`define AVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/avt_pkg.sv =====
`default_nettype none

package avt_pkg;

    // fixed-point format of the factors
    localparam int FRAC_BITS = 12;

    // field widths
    localparam int X_W     = 10;
    localparam int Y_W     = 9;
    localparam int FAC_W   = 24;
    localparam int OUT_W   = 16;
    localparam int CFG_IDX_W = 2;

    // working width of the datapath: largest product plus headroom for the adds
    localparam int ACC_W = FAC_W + X_W + 2;

    // stream widths, padded to whole bytes
    localparam int IN_TDATA_W  = ((X_W + Y_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * OUT_W + 7) / 8) * 8;

    // screen mapping offsets
    localparam int SCREEN_X_OFS = 319;
    localparam int SCREEN_Y_OFS = 239;

    // 1.0 in the factor format
    localparam logic signed [FAC_W-1:0] FIX_ONE = FAC_W'(1 << FRAC_BITS);

    // saturation limits at the working width
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(1 << (OUT_W - 1));

    typedef enum logic [2:0] {
        MODE_TRANSLATE = 3'd0,
        MODE_SCALE     = 3'd1,
        MODE_REFLECT   = 3'd2,
        MODE_ROTATE    = 3'd3,
        MODE_SHEAR     = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,   // mirror in the x axis: negate y
        AXIS_Y    = 2'd1,   // mirror in the y axis: negate x
        AXIS_BOTH = 2'd2
    } t_axis;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE     = 2'd0,
        CFG_FACTOR_X = 2'd1,
        CFG_FACTOR_Y = 2'd2,
        CFG_AXIS     = 2'd3
    } t_cfg_idx;

    // fixed-point value to integer, truncated toward zero
    function automatic logic signed [ACC_W-1:0] trunc_fix(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] q;
        logic                    rnd;
        q   = v >>> FRAC_BITS;
        rnd = v[ACC_W-1] && (v[FRAC_BITS-1:0] != '0);
        return q + ACC_W'(rnd);
    endfunction

    // clamp to the output range
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[OUT_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[OUT_W-1:0];
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

    function automatic logic is_clipped(input logic signed [ACC_W-1:0] v);
        return (v > SAT_MAX) || (v < SAT_MIN);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/affine_vertex_transform_2d_top.sv =====
`default_nettype none

// 2D affine vertex transform. Each input beat carries one vertex (x, y) and
// yields exactly one output beat (x' + 319, 239 - y', each clamped to 16 bits,
// with a flag in tuser when either was clamped). The block takes one vertex per
// clock cycle while the receiver is ready. A result is on the output once it
// moves from the input register into the result register, and it leaves at the
// first edge at which the receiver is ready. Between the two registers sits one
// 24 x 10 or 24 x 9 bit multiplier per product term followed by two truncating adds,
// which is the longest path. Mode, factors and reflect axis are written over
// the configuration channel, which is always ready; write them only while no
// vertex is in flight. Factors are signed Q12.12; in rotate mode factor_x holds
// the cosine and factor_y the sine.
module affine_vertex_transform_2d_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input vertex stream
    input  wire logic                               i_s_tvalid,
    output      logic                               o_s_tready,
    // tdata: vertex_x [9:0], vertex_y [18:10], zero pad above
    input  wire logic [avt_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // result stream
    output      logic                               o_m_tvalid,
    input  wire logic                               i_m_tready,
    // tdata: screen_x [15:0], screen_y [31:16]
    output      logic [avt_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // tuser: saturated [0]
    output      logic                               o_m_tuser,
    // configuration write channel
    input  wire logic                               i_cfg_valid,
    output      logic                               o_cfg_ready,
    input  wire logic [avt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [avt_pkg::FAC_W-1:0]          i_cfg_data
);

    import avt_pkg::*;

`include "affine_vertex_transform_2d_top_defines.svh"

    // configuration registers
    t_mode                   r_mode;
    logic signed [FAC_W-1:0] r_fx;
    logic signed [FAC_W-1:0] r_fy;
    t_axis                   r_axis;

    // input register
    logic                    r_s1_valid;
    logic signed [X_W-1:0]   r_x;
    logic signed [Y_W-1:0]   r_y;

    // result register
    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_sx;
    logic signed [OUT_W-1:0] r_sy;
    logic                    r_sat;

    logic                    w_s_beat;
    logic                    w_advance;

    // datapath
    logic signed [FAC_W-1:0]       w_sx_fac;
    logic signed [FAC_W-1:0]       w_sy_fac;
    logic signed [FAC_W+X_W-1:0]   w_p_xx;
    logic signed [FAC_W+Y_W-1:0]   w_p_yy;
    logic signed [FAC_W+X_W-1:0]   w_p_yx;
    logic signed [FAC_W+Y_W-1:0]   w_p_xy;
    logic signed [ACC_W-1:0]       w_xx;
    logic signed [ACC_W-1:0]       w_yy;
    logic signed [ACC_W-1:0]       w_yx;
    logic signed [ACC_W-1:0]       w_xy;
    logic signed [ACC_W-1:0]       w_x;
    logic signed [ACC_W-1:0]       w_y;
    logic signed [ACC_W-1:0]       w_nx;
    logic signed [ACC_W-1:0]       w_ny;
    logic signed [ACC_W-1:0]       w_ex;
    logic signed [ACC_W-1:0]       w_ey;
    logic signed [OUT_W-1:0]       n_sx;
    logic signed [OUT_W-1:0]       n_sy;
    logic                          n_sat;

    // terms for the checks
    logic                          w_s1_stall;
    logic                          w_at_limit;

    // handshakes: the input register moves on whenever the result register frees up
    assign w_advance  = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_s1_valid || w_advance;
    assign w_s_beat   = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_TRANSLATE;
            r_fx   <= FIX_ONE;
            r_fy   <= FIX_ONE;
            r_axis <= AXIS_X;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MODE:     r_mode <= t_mode'(i_cfg_data[2:0]);
                CFG_FACTOR_X: r_fx   <= i_cfg_data;
                CFG_FACTOR_Y: r_fy   <= i_cfg_data;
                CFG_AXIS:     r_axis <= t_axis'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (w_s_beat) begin
            r_x <= i_s_tdata[X_W-1:0];
            r_y <= i_s_tdata[X_W+Y_W-1:X_W];
        end
    end

    // scale mode treats a zero factor as 1.0
    assign w_sx_fac = (r_mode == MODE_SCALE && r_fx == '0) ? FIX_ONE : r_fx;
    assign w_sy_fac = (r_mode == MODE_SCALE && r_fy == '0) ? FIX_ONE : r_fy;

    // the four product terms
    assign w_p_xx = w_sx_fac * r_x;
    assign w_p_yy = w_sy_fac * r_y;
    assign w_p_yx = r_fy * r_x;
    assign w_p_xy = r_fx * r_y;

    assign w_xx = ACC_W'(w_p_xx);
    assign w_yy = ACC_W'(w_p_yy);
    assign w_yx = ACC_W'(w_p_yx);
    assign w_xy = ACC_W'(w_p_xy);
    assign w_x  = ACC_W'(r_x);
    assign w_y  = ACC_W'(r_y);

    // per-mode transform, adds in row order x, y, 1 with truncation after each
    always_comb begin
        w_nx = w_x;
        w_ny = w_y;
        unique case (r_mode)
            MODE_TRANSLATE: begin
                w_nx = w_x + trunc_fix(ACC_W'(r_fx));
                w_ny = w_y + trunc_fix(ACC_W'(r_fy));
            end
            MODE_SCALE: begin
                w_nx = trunc_fix(w_xx);
                w_ny = trunc_fix(w_yy);
            end
            MODE_REFLECT: begin
                unique case (r_axis)
                    AXIS_X:    w_ny = -w_y;
                    AXIS_Y:    w_nx = -w_x;
                    AXIS_BOTH: begin
                        w_nx = -w_x;
                        w_ny = -w_y;
                    end
                    default: ;
                endcase
            end
            MODE_ROTATE: begin
                w_nx = trunc_fix((trunc_fix(w_xx) <<< FRAC_BITS) - w_yy);
                w_ny = trunc_fix((trunc_fix(w_yx) <<< FRAC_BITS) + w_xy);
            end
            MODE_SHEAR: begin
                w_nx = trunc_fix((w_x <<< FRAC_BITS) + w_xy);
                w_ny = trunc_fix(w_yx) + w_y;
            end
            default: ;
        endcase
    end

    // screen mapping and clamp
    assign w_ex  = w_nx + ACC_W'(SCREEN_X_OFS);
    assign w_ey  = ACC_W'(SCREEN_Y_OFS) - w_ny;
    assign n_sx  = sat_out(w_ex);
    assign n_sy  = sat_out(w_ey);
    assign n_sat = is_clipped(w_ex) || is_clipped(w_ey);

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (w_advance && r_s1_valid) begin
            r_sx  <= n_sx;
            r_sy  <= n_sy;
            r_sat <= n_sat;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'({r_sy, r_sx});
    assign o_m_tuser  = r_sat;

    // check terms
    assign w_s1_stall = r_s1_valid && !w_advance;
    assign w_at_limit = (r_sx == SAT_MAX[OUT_W-1:0]) || (r_sx == SAT_MIN[OUT_W-1:0]) ||
                        (r_sy == SAT_MAX[OUT_W-1:0]) || (r_sy == SAT_MIN[OUT_W-1:0]);

    // checks
    `AVT_ASSERT_NEXT(a_beat_lands, i_clk, i_rst_n, w_s_beat, r_s1_valid)
    `AVT_ASSERT_NEXT(a_stage_moves, i_clk, i_rst_n, r_s1_valid && w_advance, r_out_valid)
    `AVT_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, w_s1_stall, r_s1_valid && $stable({r_x, r_y}))
    `AVT_ASSERT_NOW(a_sat_at_limit, i_clk, i_rst_n, r_out_valid && r_sat, w_at_limit)

endmodule

`default_nettype wire
